>>> sv/ccbe_pkg.sv
// shared constants for the character canvas buffer engine
// field widths, command codes, pass kinds and character codes; no dependencies
`default_nettype none

package ccbe_pkg;

  // beat field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SHIFT_W  = 8;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;

  // default canvas geometry
  localparam int unsigned DEFAULT_ROWS = 22;
  localparam int unsigned DEFAULT_COLS = 80;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_BEGIN_EDIT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_KEY        = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REPLACE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MOVE       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_UNDO       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READ_CELL  = 3'd6;

  // whole-buffer pass kinds
  localparam int unsigned PASS_W = 3;
  localparam logic [PASS_W-1:0] PASS_INIT  = 3'd0;  // both stores to spaces
  localparam logic [PASS_W-1:0] PASS_COPY  = 3'd1;  // canvas into backup
  localparam logic [PASS_W-1:0] PASS_REPL  = 3'd2;  // snapshot and substitute
  localparam logic [PASS_W-1:0] PASS_SHIFT = 3'd3;  // backup shifted into canvas
  localparam logic [PASS_W-1:0] PASS_UNDO  = 3'd4;  // backup into canvas
  localparam logic [PASS_W-1:0] PASS_CLEAR = 3'd5;  // canvas to spaces

  // character and key codes
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] ARROW_LEFT  = 8'd75;
  localparam logic [CHAR_W-1:0] ARROW_UP    = 8'd72;
  localparam logic [CHAR_W-1:0] ARROW_RIGHT = 8'd77;
  localparam logic [CHAR_W-1:0] ARROW_DOWN  = 8'd80;
  localparam logic [CHAR_W-1:0] PRINT_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH  = 8'd126;

endpackage

`default_nettype wire

>>> sv/ccbe_ram.sv
// generic single-write, single-read memory with registered read data
// used for the canvas and backup stores; no dependencies
`default_nettype none

module ccbe_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned DEPTH     = 1760,
  parameter int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/character_canvas_buffer_engine_core.sv
// top level of the character canvas buffer engine
// uses ccbe_pkg and two ccbe_ram instances (canvas and backup stores)
`default_nettype none

// Character canvas of ROWS x COLS 8-bit cells with a backup copy for undo and
// a clamped cursor. One command beat in gives exactly one result beat out.
// begin_edit, replace, undo and clear each sweep the buffer once through the
// two memory ports, one cell per cycle. move sweeps twice (snapshot, then
// shifted rebuild of the canvas from the backup). key, read_cell and the
// unused code do not sweep the buffer. in_ready_o is high only while the
// sequencer is idle. After reset a clearing pass writes spaces into both
// stores before the first command is taken. A finished result sits in the
// output register until taken; the next command may be accepted meanwhile,
// but its own result waits for the register.

module character_canvas_buffer_engine_core #(
  parameter int unsigned ROWS = ccbe_pkg::DEFAULT_ROWS,
  parameter int unsigned COLS = ccbe_pkg::DEFAULT_COLS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // command channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [ccbe_pkg::ACTION_W-1:0] action_i,
  input  wire logic        [ccbe_pkg::CHAR_W-1:0]   key_code_i,
  input  wire logic                                key_special_i,
  input  wire logic        [ccbe_pkg::CHAR_W-1:0]   old_char_i,
  input  wire logic        [ccbe_pkg::CHAR_W-1:0]   new_char_i,
  input  wire logic signed [ccbe_pkg::SHIFT_W-1:0]  row_shift_i,
  input  wire logic signed [ccbe_pkg::SHIFT_W-1:0]  col_shift_i,
  input  wire logic        [ccbe_pkg::ROW_W-1:0]    read_row_i,
  input  wire logic        [ccbe_pkg::COL_W-1:0]    read_col_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [ccbe_pkg::ROW_W-1:0]    cursor_row_o,
  output logic             [ccbe_pkg::COL_W-1:0]    cursor_col_o,
  output logic             [ccbe_pkg::CHAR_W-1:0]   cell_char_o,
  output logic                                     cell_written_o
);

  import ccbe_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
  // signed source coordinate width for move: holds sweep coordinate range minus a shift
  localparam int unsigned SW    = 10;

  // sequencer states
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_PASS   = 3'd1;  // issue one cell per cycle
  localparam logic [ST_W-1:0] S_DRAIN  = 3'd2;  // last write of a pass
  localparam logic [ST_W-1:0] S_RDWAIT = 3'd3;  // read_cell data comes back
  localparam logic [ST_W-1:0] S_DONE   = 3'd4;  // hand result to output reg

  logic [ST_W-1:0]   state_q, state_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              move_q, move_d;       // copy pass is followed by shift pass

  // sweep counters
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [AW-1:0] addr_q, addr_d;

  // write stage of the sweep
  logic          p1_valid_q, p1_valid_d;
  logic [AW-1:0] p1_addr_q;
  logic          p1_ok_q;

  // command operands
  logic [CHAR_W-1:0]  old_q, new_q;
  logic [SHIFT_W-1:0] dr_q, dc_q;

  // cursor and result
  logic [RW-1:0]     crow_q, crow_d;
  logic [CW-1:0]     ccol_q, ccol_d;
  logic              wr_q, wr_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              out_valid_q, out_valid_d;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_wr_q;
  logic              out_load;

  // memory ports
  logic              cv_we, cv_re, bk_we, bk_re;
  logic [AW-1:0]     cv_waddr, cv_raddr, bk_raddr;
  logic [CHAR_W-1:0] cv_wdata, bk_wdata, cv_rdata, bk_rdata;

  logic              in_fire;
  logic              last_cell;
  logic              printable;
  logic              read_in_range;
  logic [AW-1:0]     cursor_addr;
  logic [AW-1:0]     read_addr;

  // source coordinates for the shifted rebuild
  logic signed [SW-1:0] src_r, src_c;
  logic                 src_ok;
  logic [AW-1:0]        src_addr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_cell  = (addr_q == AW'(CELLS - 1));

  assign printable = !key_special_i && (key_code_i >= PRINT_LOW) &&
                     (key_code_i <= PRINT_HIGH);
  assign read_in_range = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLS);

  assign cursor_addr = AW'(crow_q) * AW'(COLS) + AW'(ccol_q);
  assign read_addr   = AW'(read_row_i) * AW'(COLS) + AW'(read_col_i);

  // destination (r, c) takes from (r - dr, c - dc), out of range gives a space
  assign src_r  = $signed({{(SW-RW){1'b0}}, r_q}) -
                  $signed({{(SW-SHIFT_W){dr_q[SHIFT_W-1]}}, dr_q});
  assign src_c  = $signed({{(SW-CW){1'b0}}, c_q}) -
                  $signed({{(SW-SHIFT_W){dc_q[SHIFT_W-1]}}, dc_q});
  assign src_ok = !src_r[SW-1] && (src_r[SW-2:0] < (SW-1)'(ROWS)) &&
                  !src_c[SW-1] && (src_c[SW-2:0] < (SW-1)'(COLS));
  assign src_addr = AW'(src_r[SW-2:0]) * AW'(COLS) + AW'(src_c[SW-2:0]);

  // read side: canvas feeds copy and replace passes plus read_cell,
  // backup feeds shift and undo passes
  always_comb begin
    cv_re    = 1'b0;
    cv_raddr = addr_q;
    bk_re    = 1'b0;
    bk_raddr = addr_q;
    if (state_q == S_PASS) begin
      cv_re = (pass_q == PASS_COPY) || (pass_q == PASS_REPL);
      bk_re = (pass_q == PASS_SHIFT) || (pass_q == PASS_UNDO);
      if (pass_q == PASS_SHIFT) begin
        bk_raddr = src_addr;
      end
    end else if (in_fire && (action_i == ACT_READ_CELL) && read_in_range) begin
      cv_re    = 1'b1;
      cv_raddr = read_addr;
    end
  end

  // write side: sweep write stage, or a keystroke at the cursor
  always_comb begin
    cv_we    = 1'b0;
    cv_waddr = p1_addr_q;
    cv_wdata = SPACE_CHAR;
    bk_we    = 1'b0;
    bk_wdata = cv_rdata;
    if (p1_valid_q) begin
      case (pass_q)
        PASS_INIT: begin
          cv_we    = 1'b1;
          bk_we    = 1'b1;
          bk_wdata = SPACE_CHAR;
        end
        PASS_COPY: begin
          bk_we = 1'b1;
        end
        PASS_REPL: begin
          cv_we    = 1'b1;
          bk_we    = 1'b1;
          cv_wdata = (cv_rdata == old_q) ? new_q : cv_rdata;
        end
        PASS_SHIFT: begin
          cv_we    = 1'b1;
          cv_wdata = p1_ok_q ? bk_rdata : SPACE_CHAR;
        end
        PASS_UNDO: begin
          cv_we    = 1'b1;
          cv_wdata = bk_rdata;
        end
        PASS_CLEAR: begin
          cv_we = 1'b1;
        end
        default: begin
          cv_we = 1'b0;
        end
      endcase
    end else if (in_fire && (action_i == ACT_KEY) && printable) begin
      cv_we    = 1'b1;
      cv_waddr = cursor_addr;
      cv_wdata = key_code_i;
    end
  end

  ccbe_ram #(
    .WIDTH  (CHAR_W),
    .DEPTH  (CELLS),
    .ADDR_W (AW)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .waddr_i (cv_waddr),
    .wdata_i (cv_wdata),
    .re_i    (cv_re),
    .raddr_i (cv_raddr),
    .rdata_o (cv_rdata)
  );

  ccbe_ram #(
    .WIDTH  (CHAR_W),
    .DEPTH  (CELLS),
    .ADDR_W (AW)
  ) u_backup (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (p1_addr_q),
    .wdata_i (bk_wdata),
    .re_i    (bk_re),
    .raddr_i (bk_raddr),
    .rdata_o (bk_rdata)
  );

  // output register frees the sequencer from the result channel
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    move_d     = move_q;
    r_d        = r_q;
    c_d        = c_q;
    addr_d     = addr_q;
    p1_valid_d = 1'b0;
    crow_d     = crow_q;
    ccol_d     = ccol_q;
    wr_d       = wr_q;
    char_d     = char_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          r_d    = '0;
          c_d    = '0;
          addr_d = '0;
          move_d = 1'b0;
          wr_d   = 1'b0;
          char_d = '0;
          case (action_i)
            ACT_BEGIN_EDIT: begin
              crow_d  = '0;
              ccol_d  = '0;
              pass_d  = PASS_COPY;
              state_d = S_PASS;
            end
            ACT_KEY: begin
              state_d = S_DONE;
              if (key_special_i) begin
                // arrows stop at the edges, other scan codes do nothing
                if (key_code_i == ARROW_DOWN) begin
                  if (crow_q != RW'(ROWS - 1)) crow_d = crow_q + 1'b1;
                end else if (key_code_i == ARROW_UP) begin
                  if (crow_q != '0) crow_d = crow_q - 1'b1;
                end else if (key_code_i == ARROW_RIGHT) begin
                  if (ccol_q != CW'(COLS - 1)) ccol_d = ccol_q + 1'b1;
                end else if (key_code_i == ARROW_LEFT) begin
                  if (ccol_q != '0) ccol_d = ccol_q - 1'b1;
                end
              end else begin
                wr_d = printable;
              end
            end
            ACT_REPLACE: begin
              pass_d  = PASS_REPL;
              state_d = S_PASS;
            end
            ACT_MOVE: begin
              pass_d  = PASS_COPY;
              move_d  = 1'b1;
              state_d = S_PASS;
            end
            ACT_UNDO: begin
              pass_d  = PASS_UNDO;
              state_d = S_PASS;
            end
            ACT_CLEAR: begin
              pass_d  = PASS_CLEAR;
              state_d = S_PASS;
            end
            ACT_READ_CELL: begin
              state_d = read_in_range ? S_RDWAIT : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PASS: begin
        p1_valid_d = 1'b1;
        addr_d     = addr_q + 1'b1;
        if (c_q == CW'(COLS - 1)) begin
          c_d = '0;
          r_d = r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
        if (last_cell) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        r_d    = '0;
        c_d    = '0;
        addr_d = '0;
        if (pass_q == PASS_INIT) begin
          state_d = S_IDLE;
        end else if (move_q && (pass_q == PASS_COPY)) begin
          // snapshot done, rebuild the canvas from the backup
          pass_d  = PASS_SHIFT;
          state_d = S_PASS;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        char_d  = cv_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state; reset starts the clearing pass over both stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PASS;
      pass_q      <= PASS_INIT;
      move_q      <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      addr_q      <= '0;
      p1_valid_q  <= 1'b0;
      crow_q      <= '0;
      ccol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      move_q      <= move_d;
      r_q         <= r_d;
      c_q         <= c_d;
      addr_q      <= addr_d;
      p1_valid_q  <= p1_valid_d;
      crow_q      <= crow_d;
      ccol_q      <= ccol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p1_addr_q <= addr_q;
    p1_ok_q   <= src_ok;
    wr_q      <= wr_d;
    char_q    <= char_d;
    if (in_fire) begin
      old_q <= old_char_i;
      new_q <= new_char_i;
      dr_q  <= row_shift_i;
      dc_q  <= col_shift_i;
    end
    if (out_load) begin
      out_row_q  <= ROW_W'(crow_q);
      out_col_q  <= COL_W'(ccol_q);
      out_char_q <= char_q;
      out_wr_q   <= wr_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_row_o   = out_row_q;
  assign cursor_col_o   = out_col_q;
  assign cell_char_o    = out_char_q;
  assign cell_written_o = out_wr_q;

endmodule

`default_nettype wire

>>> verif/canvas_scoreboard_pkg.sv
// predictor and result scoreboard for the character canvas buffer engine
// depends on ccbe_pkg for field widths, command codes and character codes
`timescale 1ns / 100ps

package canvas_scoreboard_pkg;
  import ccbe_pkg::*;

  localparam int N_ROWS  = int'(DEFAULT_ROWS);
  localparam int N_COLS  = int'(DEFAULT_COLS);
  localparam int N_CELLS = N_ROWS * N_COLS;

  // the one command code the package leaves unnamed
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic [CHAR_W-1:0]         key_code;
    logic                      key_special;
    logic [CHAR_W-1:0]         old_char;
    logic [CHAR_W-1:0]         new_char;
    logic signed [SHIFT_W-1:0] row_shift;
    logic signed [SHIFT_W-1:0] col_shift;
    logic [ROW_W-1:0]          read_row;
    logic [COL_W-1:0]          read_col;
  } canvas_cmd_t;

  typedef struct {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_char;
    logic              cell_written;
  } canvas_result_t;

  class canvas_scoreboard;
    bit [CHAR_W-1:0] canvas [N_CELLS];
    bit [CHAR_W-1:0] backup [N_CELLS];
    bit [ROW_W-1:0]  cur_row;
    bit [COL_W-1:0]  cur_col;
    canvas_result_t  expected_q [$];
    int unsigned     mismatches;

    function new();
      foreach (canvas[i]) begin
        canvas[i] = SPACE_CHAR;
        backup[i] = SPACE_CHAR;
      end
      cur_row    = '0;
      cur_col    = '0;
      mismatches = 0;
    endfunction

    function int cell_at(int r, int c);
      return r * N_COLS + c;
    endfunction

    // apply one accepted command and queue the result it must produce
    function void note_command(canvas_cmd_t cmd);
      canvas_result_t res;
      int src_row;
      int src_col;
      res.cell_char    = '0;
      res.cell_written = 1'b0;
      case (cmd.action)
        ACT_BEGIN_EDIT: begin
          backup  = canvas;
          cur_row = '0;
          cur_col = '0;
        end
        ACT_KEY: begin
          if (cmd.key_special) begin
            if (cmd.key_code == ARROW_DOWN) begin
              if (cur_row < N_ROWS - 1) cur_row = cur_row + 1'b1;
            end else if (cmd.key_code == ARROW_UP) begin
              if (cur_row > 0) cur_row = cur_row - 1'b1;
            end else if (cmd.key_code == ARROW_RIGHT) begin
              if (cur_col < N_COLS - 1) cur_col = cur_col + 1'b1;
            end else if (cmd.key_code == ARROW_LEFT) begin
              if (cur_col > 0) cur_col = cur_col - 1'b1;
            end
          end else if (cmd.key_code >= PRINT_LOW && cmd.key_code <= PRINT_HIGH) begin
            canvas[cell_at(cur_row, cur_col)] = cmd.key_code;
            res.cell_written = 1'b1;
          end
        end
        ACT_REPLACE: begin
          backup = canvas;
          foreach (canvas[i])
            if (canvas[i] == cmd.old_char) canvas[i] = cmd.new_char;
        end
        ACT_MOVE: begin
          // backup now holds the old canvas, so rebuild straight from it
          backup = canvas;
          for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_COLS; c++) begin
              src_row = r - int'(cmd.row_shift);
              src_col = c - int'(cmd.col_shift);
              if (src_row >= 0 && src_row < N_ROWS && src_col >= 0 && src_col < N_COLS)
                canvas[cell_at(r, c)] = backup[cell_at(src_row, src_col)];
              else
                canvas[cell_at(r, c)] = SPACE_CHAR;
            end
        end
        ACT_UNDO:  canvas = backup;
        ACT_CLEAR: foreach (canvas[i]) canvas[i] = SPACE_CHAR;
        ACT_READ_CELL: begin
          if (cmd.read_row < N_ROWS && cmd.read_col < N_COLS)
            res.cell_char = canvas[cell_at(cmd.read_row, cmd.read_col)];
        end
        default: ;
      endcase
      res.cursor_row = cur_row;
      res.cursor_col = cur_col;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(canvas_result_t got);
      canvas_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d col %0d char %0h wr %0b",
                 $time, got.cursor_row, got.cursor_col, got.cell_char, got.cell_written);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("cell_char", want.cell_char, got.cell_char);
      compare_field("cell_written", want.cell_written, got.cell_written);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> verif/character_canvas_buffer_engine_core_test.sv
// self-checking bench for character_canvas_buffer_engine_core
// depends on ccbe_pkg and canvas_scoreboard_pkg; drives commands, checks every result beat
`timescale 1ns / 100ps

module character_canvas_buffer_engine_core_test;
  import ccbe_pkg::*;
  import canvas_scoreboard_pkg::*;

  // run shape
  localparam int TOTAL_ITEMS     = 290;
  localparam int IDLE_PERCENT    = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  // longest quiet stretch: a move sweeps the buffer twice, plus the long hold-off
  localparam int WATCHDOG_LIMIT  = 4 * (2 * N_CELLS + 4) + HOLD_OFF_CYCLES;

  logic clk = 1'b0;
  logic rst_n;

  // command channel
  logic                      in_valid;
  logic                      in_ready;
  logic [ACTION_W-1:0]       action;
  logic [CHAR_W-1:0]         key_code;
  logic                      key_special;
  logic [CHAR_W-1:0]         old_char;
  logic [CHAR_W-1:0]         new_char;
  logic signed [SHIFT_W-1:0] row_shift;
  logic signed [SHIFT_W-1:0] col_shift;
  logic [ROW_W-1:0]          read_row;
  logic [COL_W-1:0]          read_col;

  // result channel
  logic              out_valid;
  logic              out_ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic              cell_written;

  canvas_scoreboard board;
  canvas_result_t   seen_result;
  int unsigned      items_sent;
  int unsigned      quiet_cycles = 0;
  bit               steady;        // both sides stop idling while set
  bit               hold_off_req;  // asks the receiver for its long stall

  always #5 clk = ~clk;

  character_canvas_buffer_engine_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .key_code_i     (key_code),
    .key_special_i  (key_special),
    .old_char_i     (old_char),
    .new_char_i     (new_char),
    .row_shift_i    (row_shift),
    .col_shift_i    (col_shift),
    .read_row_i     (read_row),
    .read_col_i     (read_col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .cursor_row_o   (cursor_row),
    .cursor_col_o   (cursor_col),
    .cell_char_o    (cell_char),
    .cell_written_o (cell_written)
  );

  // ---------------------------------------------------------------------------
  // command beat driver: called at a falling edge, returns at a falling edge
  // right after the beat was taken; valid stays up between back-to-back beats
  // ---------------------------------------------------------------------------
  task automatic send_command(input canvas_cmd_t cmd);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= cmd.action;
    key_code    <= cmd.key_code;
    key_special <= cmd.key_special;
    old_char    <= cmd.old_char;
    new_char    <= cmd.new_char;
    row_shift   <= cmd.row_shift;
    col_shift   <= cmd.col_shift;
    read_row    <= cmd.read_row;
    read_col    <= cmd.read_col;
    // ready is sampled at the rising edge, before the block updates it
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd);
    items_sent++;
    @(negedge clk);
  endtask

  // every field random, so fields a command ignores still toggle every bit
  function automatic canvas_cmd_t noisy_cmd(input logic [ACTION_W-1:0] act);
    canvas_cmd_t cmd;
    cmd.action      = act;
    cmd.key_code    = CHAR_W'($urandom_range(255));
    cmd.key_special = 1'($urandom_range(1));
    cmd.old_char    = CHAR_W'($urandom_range(255));
    cmd.new_char    = CHAR_W'($urandom_range(255));
    cmd.row_shift   = SHIFT_W'($urandom_range(255));
    cmd.col_shift   = SHIFT_W'($urandom_range(255));
    cmd.read_row    = ROW_W'($urandom_range(31));
    cmd.read_col    = COL_W'($urandom_range(127));
    return cmd;
  endfunction

  // small alphabet most of the time so that replace finds its targets
  function automatic logic [CHAR_W-1:0] some_char();
    if ($urandom_range(99) < 60) return 8'($urandom_range(72, 65));
    return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
  endfunction

  function automatic logic [CHAR_W-1:0] some_arrow();
    case ($urandom_range(3))
      0:       return ARROW_LEFT;
      1:       return ARROW_UP;
      2:       return ARROW_RIGHT;
      default: return ARROW_DOWN;
    endcase
  endfunction

  task automatic issue_plain(input logic [ACTION_W-1:0] act);
    send_command(noisy_cmd(act));
  endtask

  task automatic issue_key(input logic [CHAR_W-1:0] code, input logic special);
    canvas_cmd_t cmd;
    cmd             = noisy_cmd(ACT_KEY);
    cmd.key_code    = code;
    cmd.key_special = special;
    send_command(cmd);
  endtask

  task automatic issue_read(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    canvas_cmd_t cmd;
    cmd          = noisy_cmd(ACT_READ_CELL);
    cmd.read_row = r;
    cmd.read_col = c;
    send_command(cmd);
  endtask

  task automatic issue_replace(input logic [CHAR_W-1:0] from_c, input logic [CHAR_W-1:0] to_c);
    canvas_cmd_t cmd;
    cmd          = noisy_cmd(ACT_REPLACE);
    cmd.old_char = from_c;
    cmd.new_char = to_c;
    send_command(cmd);
  endtask

  task automatic issue_move(input logic signed [SHIFT_W-1:0] dr,
                            input logic signed [SHIFT_W-1:0] dc);
    canvas_cmd_t cmd;
    cmd           = noisy_cmd(ACT_MOVE);
    cmd.row_shift = dr;
    cmd.col_shift = dc;
    send_command(cmd);
  endtask

  // read the cursor cell, some cell on the canvas, or anywhere the fields reach
  task automatic issue_probe();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)
      issue_read(board.cur_row, board.cur_col);
    else if (pick < 85)
      issue_read(ROW_W'($urandom_range(N_ROWS - 1)), COL_W'($urandom_range(N_COLS - 1)));
    else
      issue_read(ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
  endtask

  // valid drops first so that no stale beat is offered while the block drains
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // directed part: field extremes, every command, clamps and ignored keys
  // ---------------------------------------------------------------------------
  task automatic run_directed();
    issue_read(5'd0, 7'd0);                   // fresh canvas holds spaces
    issue_read(ROW_W'(N_ROWS - 1), COL_W'(N_COLS - 1));  // last cell
    issue_read(ROW_W'(N_ROWS), 7'd0);         // row just past the buffer
    issue_read(5'd31, 7'd127);                // both coordinates at field max
    issue_key(ARROW_LEFT, 1'b1);              // clamp at left edge
    issue_key(ARROW_UP, 1'b1);                // clamp at top edge
    issue_key(PRINT_LOW, 1'b0);               // lowest printable, no begin_edit yet
    issue_key(PRINT_HIGH, 1'b0);              // highest printable
    issue_key(8'd127, 1'b0);                  // just above printable range
    issue_key(8'd31, 1'b0);                   // control code
    issue_key(8'd224, 1'b0);                  // prefix byte as a plain key
    issue_key(8'd0, 1'b0);
    issue_key(ARROW_RIGHT, 1'b1);
    issue_key(ARROW_DOWN, 1'b1);
    issue_key(8'd65, 1'b0);                   // 'A' at row 1, col 1
    issue_key(8'd65, 1'b1);                   // special code that is no arrow
    issue_plain(ACT_BEGIN_EDIT);              // snapshot and home
    issue_replace(8'd65, 8'hff);
    issue_read(5'd1, 7'd1);
    issue_move(8'sd1, 8'sd1);
    issue_move(-8'sd128, 8'sd127);            // everything falls off
    issue_plain(ACT_UNDO);                    // back to the one-step shifted canvas
    issue_read(5'd2, 7'd2);
    issue_plain(ACT_CLEAR);
    issue_plain(ACT_UNUSED);
  endtask

  // ---------------------------------------------------------------------------
  // random part: mostly edit sessions and whole-buffer commands followed by
  // reads, so the canvas content is actually observed; some pure noise
  // ---------------------------------------------------------------------------
  task automatic run_random();
    int unsigned pick;
    int unsigned n;
    bit          drained_once;
    drained_once = 1'b0;

    // fill the block while the receiver holds off
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) issue_key(some_char(), 1'b0);
      else issue_read(board.cur_row, board.cur_col);
    end

    // walk to the right edge and past it, writing now and then; no idling here
    steady = 1'b1;
    for (int i = 0; i < N_COLS + 4; i++) begin
      if (i % 8 == 7) issue_key(some_char(), 1'b0);
      issue_key(ARROW_RIGHT, 1'b1);
    end
    steady = 1'b0;
    for (int i = 0; i < N_ROWS + 2; i++) begin
      if (i % 6 == 5) issue_key(some_char(), 1'b0);
      issue_key(ARROW_DOWN, 1'b1);
    end
    issue_key(some_char(), 1'b0);             // write in the bottom-right corner
    issue_read(ROW_W'(N_ROWS - 1), COL_W'(N_COLS - 1));

    while (items_sent < TOTAL_ITEMS) begin
      // one full pause with the block empty
      if (!drained_once && items_sent >= TOTAL_ITEMS - 60) begin
        wait_drained();
        drained_once = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        // edit session: begin_edit, a few keystrokes, then look around
        issue_plain(ACT_BEGIN_EDIT);
        n = $urandom_range(10, 3);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 45) issue_key(some_arrow(), 1'b1);
          else if (pick < 90) issue_key(some_char(), 1'b0);
          else issue_key(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        repeat ($urandom_range(3, 1)) issue_probe();
      end else if (pick < 75) begin
        // whole-buffer command, then reads to see its effect
        pick = $urandom_range(99);
        if (pick < 35)
          issue_replace(($urandom_range(99) < 60) ? some_char() :
                        ($urandom_range(1) ? SPACE_CHAR : 8'($urandom_range(255))),
                        $urandom_range(1) ? some_char() : 8'($urandom_range(255)));
        else if (pick < 70) begin
          if ($urandom_range(99) < 70)
            issue_move(SHIFT_W'($urandom_range(6) - 3), SHIFT_W'($urandom_range(6) - 3));
          else
            issue_move(SHIFT_W'($urandom_range(255)), SHIFT_W'($urandom_range(255)));
        end else if (pick < 85)
          issue_plain(ACT_UNDO);
        else
          issue_plain(ACT_CLEAR);
        repeat ($urandom_range(3, 1)) issue_probe();
      end else if (pick < 90) begin
        if ($urandom_range(1)) issue_key(some_arrow(), 1'b1);
        else issue_probe();
      end else begin
        send_command(noisy_cmd(ACTION_W'($urandom_range(7))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready changes at the falling edge, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // result beats are taken and checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.cursor_row   = cursor_row;
      seen_result.cursor_col   = cursor_col;
      seen_result.cell_char    = cell_char;
      seen_result.cell_written = cell_written;
      board.check_result(seen_result);
    end
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board        = new();
    items_sent   = 0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    action       = ACT_BEGIN_EDIT;
    key_code     = '0;
    key_special  = 1'b0;
    old_char     = '0;
    new_char     = '0;
    row_shift    = '0;
    col_shift    = '0;
    read_row     = '0;
    read_col     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block clears both stores first; ready stays low until then
    run_directed();
    run_random();
    wait_drained();
    // room for any stray beat from a late whole-buffer sweep
    repeat (2 * N_CELLS + 8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
